// File: rtl/ckt_pkg.sv
`timescale 1ns / 1ps
package ckt_pkg;
  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int LIM_W = CNT_W + 1;
  localparam int KEY_W = 17;
  localparam logic signed [KEY_W-1:0] KEY_REJECT = 17'sh100;

  // read address select codes
  localparam logic [2:0] RD_NONE = 3'd0;
  localparam logic [2:0] RD_JM1  = 3'd1;
  localparam logic [2:0] RD_J    = 3'd2;
  localparam logic [2:0] RD_MID  = 3'd3;
  localparam logic [2:0] RD_KEY  = 3'd4;

  typedef struct packed {
    logic       cap;
    logic [2:0] rd_sel;
    logic       wr_shift;
    logic       wr_new;
    logic       j_dec;
    logic       j_clr;
    logic       j_inc;
    logic       cnt_inc;
    logic       fin_scan;
    logic       bot_up;
    logic       top_dn;
    logic       res_nf;
    logic       res_hit;
    logic       out_load;
  } ckt_cmd_t;

  typedef struct packed {
    logic lookup;
    logic last;
    logic full;
    logic rej;
    logic direct;
    logic j_zero;
    logic ins_gt;
    logic scan_end;
    logic scan_match;
    logic srch_empty;
    logic srch_eq;
    logic srch_gt;
    logic out_free;
  } ckt_sts_t;

  function automatic logic [KEY_W-1:0] abs_key(input logic signed [KEY_W-1:0] k);
    abs_key = k[KEY_W-1] ? KEY_W'(-k) : KEY_W'(k);
  endfunction
endpackage

// File: rtl/ckt_ctrl.sv
`timescale 1ns / 1ps
module ckt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ckt_pkg::ckt_sts_t sts,
  output ckt_pkg::ckt_cmd_t cmd
);
  import ckt_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DEC      = 4'd1;
  localparam logic [3:0] S_INS_RD   = 4'd2;
  localparam logic [3:0] S_INS_CMP  = 4'd3;
  localparam logic [3:0] S_INS_WR   = 4'd4;
  localparam logic [3:0] S_SCAN_RD  = 4'd5;
  localparam logic [3:0] S_SCAN_CMP = 4'd6;
  localparam logic [3:0] S_SRCH     = 4'd7;
  localparam logic [3:0] S_SCMP     = 4'd8;
  localparam logic [3:0] S_DIR      = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.rd_sel = RD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.lookup) begin
          if (sts.rej) begin
            cmd.res_nf = 1'b1;
            state_nxt = S_FIN;
          end else if (sts.direct) begin
            cmd.rd_sel = RD_KEY;
            state_nxt = S_DIR;
          end else begin
            state_nxt = S_SRCH;
          end
        end else if (sts.full) begin
          // table full: key dropped, a last mark still builds the index
          if (sts.last) begin
            cmd.j_clr = 1'b1;
            state_nxt = S_SCAN_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (sts.j_zero) begin
          state_nxt = S_INS_WR;
        end else begin
          cmd.rd_sel = RD_JM1;
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts.ins_gt) begin
          cmd.wr_shift = 1'b1;
          cmd.j_dec = 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_new = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.last) begin
          cmd.j_clr = 1'b1;
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_end) begin
          cmd.fin_scan = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_sel = RD_J;
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts.scan_match) begin
          cmd.j_inc = 1'b1;
          state_nxt = S_SCAN_RD;
        end else begin
          cmd.fin_scan = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SRCH: begin
        if (sts.srch_empty) begin
          cmd.res_nf = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.rd_sel = RD_MID;
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (sts.srch_eq) begin
          cmd.res_hit = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.bot_up = sts.srch_gt;
          cmd.top_dn = !sts.srch_gt;
          state_nxt = S_SRCH;
        end
      end
      S_DIR: begin
        cmd.res_hit = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// File: rtl/ckt_dpath.sv
`timescale 1ns / 1ps
module ckt_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_kind,
  input  logic signed [ckt_pkg::KEY_W-1:0]   in_key_code,
  input  logic                               in_last_entry,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic [7:0]                         out_entry_index,
  input  ckt_pkg::ckt_cmd_t                  cmd,
  output ckt_pkg::ckt_sts_t                  sts
);
  import ckt_pkg::*;

  localparam int WORD_W = KEY_W + ADDR_W;

  // sorted table: {signed key, load position}
  logic [WORD_W-1:0] mem [MAX_ENTRIES];
  logic [WORD_W-1:0] rd_q;

  logic                     kind_r, last_r, ready_r;
  logic signed [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]         abs_r;
  logic [CNT_W-1:0]         count_r, j_r;
  logic signed [LIM_W-1:0]  limit_r, bot_r, top_r;
  logic                     res_found_r;
  logic [ADDR_W-1:0]        res_idx_r;
  logic                     out_valid_r, out_found_r;
  logic [7:0]               out_idx_r;

  logic [CNT_W-1:0]         count_eff;
  logic signed [LIM_W:0]    mid_sum;
  logic signed [LIM_W-1:0]  mid;
  logic signed [KEY_W-1:0]  rd_key;
  logic [KEY_W-1:0]         rd_abs;
  logic [ADDR_W-1:0]        rd_idx;
  logic [ADDR_W-1:0]        raddr;
  logic                     rd_en;

  assign count_eff = ready_r ? '0 : count_r;
  assign mid_sum = {bot_r[LIM_W-1], bot_r} + {top_r[LIM_W-1], top_r};
  assign mid = mid_sum[LIM_W:1];
  assign rd_key = rd_q[WORD_W-1:ADDR_W];
  assign rd_abs = abs_key(rd_key);
  assign rd_idx = rd_q[ADDR_W-1:0];

  always_comb begin
    sts.lookup = kind_r;
    sts.last = last_r;
    sts.full = (count_r == CNT_W'(MAX_ENTRIES));
    sts.rej = !ready_r || (key_r >= KEY_REJECT);
    sts.direct = $signed({1'b0, abs_r}) <= $signed(18'(limit_r));
    sts.j_zero = (j_r == '0);
    sts.ins_gt = rd_abs > abs_r;
    sts.scan_end = (j_r == count_r);
    sts.scan_match = (rd_key == $signed(KEY_W'(j_r)));
    sts.srch_empty = bot_r > top_r;
    sts.srch_eq = (rd_abs == abs_r);
    sts.srch_gt = abs_r > rd_abs;
    sts.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    rd_en = 1'b1;
    raddr = '0;
    unique case (cmd.rd_sel)
      RD_JM1:  raddr = ADDR_W'(j_r - 1'b1);
      RD_J:    raddr = j_r[ADDR_W-1:0];
      RD_MID:  raddr = mid[ADDR_W-1:0];
      RD_KEY:  raddr = abs_r[ADDR_W-1:0];
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= mem[raddr];
    if (cmd.wr_shift) mem[j_r[ADDR_W-1:0]] <= rd_q;
    else if (cmd.wr_new) mem[j_r[ADDR_W-1:0]] <= {key_r, count_r[ADDR_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      kind_r <= in_kind;
      last_r <= in_last_entry;
      key_r <= in_key_code;
      abs_r <= abs_key(in_key_code);
      bot_r <= limit_r + 2'sd1;
      top_r <= $signed({1'b0, count_r}) - 2'sd1;
    end
    if (cmd.cap) j_r <= count_eff;
    else if (cmd.j_clr) j_r <= '0;
    else if (cmd.j_dec) j_r <= j_r - 1'b1;
    else if (cmd.j_inc) j_r <= j_r + 1'b1;
    if (cmd.bot_up) bot_r <= mid + 2'sd1;
    if (cmd.top_dn) top_r <= mid - 2'sd1;
    if (cmd.res_nf) begin
      res_found_r <= 1'b0;
      res_idx_r <= '0;
    end else if (cmd.res_hit) begin
      res_found_r <= 1'b1;
      res_idx_r <= rd_idx;
    end
    if (cmd.out_load) begin
      out_found_r <= res_found_r;
      out_idx_r <= 8'(res_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      limit_r <= '1;
      ready_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cap && !in_kind && ready_r) begin
        // a load after the table is ready starts a new table
        count_r <= '0;
        limit_r <= '1;
        ready_r <= 1'b0;
      end else if (cmd.cnt_inc) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.fin_scan) begin
        limit_r <= $signed({1'b0, j_r}) - 2'sd1;
        ready_r <= 1'b1;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_entry_index = out_idx_r;

`ifndef SYNTHESIS
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_shift && cmd.wr_new)) else $error("two writes in one cycle");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES)) else $error("entry count overflow");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready)) else $error("result overwritten");
  a_ready_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_scan |=> ready_r && (limit_r < $signed({1'b0, count_r})))
    else $error("bad direct limit");
`endif
endmodule

// File: rtl/command_key_table_lookup_top.sv
`timescale 1ns / 1ps
// command key table lookup
// input channel (in_valid/in_ready): in_kind 0 loads one table entry with key in_key_code,
//   in_last_entry marks the final entry and starts the index build; in_kind 1 looks up a key
// result channel (out_valid/out_ready): one transaction per lookup, none per load,
//   carrying out_found and out_entry_index (load position, 0 when not found)
// entries are kept sorted by absolute key through insertion on each load, using one
//   single-port table memory with a registered read
// a load shifts each larger entry up one place before writing the new one; a last entry
//   adds a scan from the table start that sets the direct limit
// a lookup reads the table directly below the direct limit, returns not found at once
//   when rejected, and otherwise runs the binary search loop
// in_ready is high only while the controller is idle; a result waits in an output
//   register, so loads are taken while it is held, and a lookup finishing while the
//   receiver stalls waits for that register to drain
// synchronous active-low reset empties the table; lookups return not found until a
//   last entry has been loaded
module command_key_table_lookup_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_kind,
  input  logic signed [ckt_pkg::KEY_W-1:0] in_key_code,
  input  logic                             in_last_entry,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_found,
  output logic [7:0]                       out_entry_index
);
  import ckt_pkg::*;

  ckt_cmd_t cmd;
  ckt_sts_t sts;

  ckt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ckt_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_kind         (in_kind),
    .in_key_code     (in_key_code),
    .in_last_entry   (in_last_entry),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_entry_index (out_entry_index),
    .cmd             (cmd),
    .sts             (sts)
  );
endmodule

// File: sim/command_key_table_lookup_top_tb.sv
`timescale 1ns / 1ps
module command_key_table_lookup_top_tb;
  import ckt_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD = 400;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct {
    logic found;
    logic [7:0] idx;
  } answer_t;

  typedef struct {
    logic kind;
    int key;
    logic last;
    bit typed;
    logic found;
    logic [7:0] idx;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = KIND_LOAD;
  logic signed [KEY_W-1:0] in_key_code = '0;
  logic in_last_entry = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  logic [7:0] out_entry_index;

  command_key_table_lookup_top dut (.*);

  // shadow of the table and its index
  int tbl_keys[MAX_ENTRIES];
  int tbl_order[MAX_ENTRIES];
  int tbl_count = 0;
  int tbl_limit = -1;
  bit tbl_ready = 0;

  answer_t answer_q[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int items = 0;
  bit hold_req = 0;
  bit done = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic int mag(input int k);
    return k < 0 ? -k : k;
  endfunction

  task automatic build_sorted_index();
    int i;
    int j;
    int cur;
    for (i = 0; i < tbl_count; i++) tbl_order[i] = i;
    for (i = 1; i < tbl_count; i++) begin
      cur = tbl_order[i];
      j = i;
      while (j > 0 && mag(tbl_keys[tbl_order[j-1]]) > mag(tbl_keys[cur])) begin
        tbl_order[j] = tbl_order[j-1];
        j--;
      end
      tbl_order[j] = cur;
    end
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_keys[tbl_order[i]] != i) break;
    end
    tbl_limit = i - 1;
    tbl_ready = 1;
  endtask

  function automatic answer_t search_table(input int key);
    answer_t a;
    int k;
    int bot;
    int top;
    int mid;
    int c;
    int hit;
    hit = -1;
    if (tbl_ready && key < 256) begin
      k = mag(key);
      if (k <= tbl_limit) begin
        hit = tbl_order[k];
      end else begin
        bot = tbl_limit + 1;
        top = tbl_count - 1;
        while (bot <= top) begin
          mid = (top + bot) / 2;
          c = mag(tbl_keys[tbl_order[mid]]);
          if (k == c) begin
            hit = tbl_order[mid];
            break;
          end
          if (k > c) bot = mid + 1;
          else top = mid - 1;
        end
      end
    end
    a.found = hit >= 0;
    a.idx = hit >= 0 ? 8'(hit) : 8'd0;
    return a;
  endfunction

  // update the shadow for one accepted transaction
  task automatic apply_item(input row_t r);
    answer_t a;
    if (r.kind == KIND_LOAD) begin
      if (tbl_ready) begin
        tbl_count = 0;
        tbl_limit = -1;
        tbl_ready = 0;
      end
      if (tbl_count < MAX_ENTRIES) begin
        tbl_keys[tbl_count] = r.key;
        tbl_count++;
      end
      if (r.last) build_sorted_index();
    end else begin
      a = search_table(r.key);
      if (r.typed) begin
        a.found = r.found;
        a.idx = r.idx;
      end
      answer_q.push_back(a);
    end
  endtask

  task automatic send(input row_t r);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid = 1'b1;
    in_kind = r.kind;
    in_key_code = KEY_W'(r.key);
    in_last_entry = r.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_item(r);
    items++;
    @(negedge clk);
  endtask

  function automatic row_t mk(input logic kind, input int key, input logic last);
    row_t r;
    r.kind = kind;
    r.key = key;
    r.last = last;
    r.typed = 0;
    r.found = 0;
    r.idx = 0;
    return r;
  endfunction

  function automatic row_t mk_exp(input int key, input logic f, input int idx);
    row_t r;
    r = mk(KIND_LOOKUP, key, $urandom_range(0, 1));
    r.typed = 1;
    r.found = f;
    r.idx = 8'(idx);
    return r;
  endfunction

  function automatic int rand_key(input int span);
    int k;
    k = $urandom_range(0, span);
    if ($urandom_range(0, 3) == 0) k = -k;
    if ($urandom_range(0, 15) == 0) k = int'($urandom_range(0, 131070)) - 65535;
    return k;
  endfunction

  // receiver: randomly switched stall patterns plus a long hold-off on each request
  initial begin
    int mode;
    int n;
    mode = 0;
    n = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 0;
      end
      if (n == 0) begin
        mode = $urandom_range(0, 3);
        n = $urandom_range(20, 200);
      end
      n--;
      case (mode)
        0: out_ready = 1'b1;
        1: out_ready = $urandom_range(0, 3) != 0;
        2: out_ready = $urandom_range(0, 3) == 0;
        default: out_ready = (cycles % 7) < 3;
      endcase
    end
  end

  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        a = answer_q.pop_front();
        if (out_found !== a.found)
          report($sformatf("found %b, expected %b", out_found, a.found));
        if (out_entry_index !== a.idx)
          report($sformatf("entry_index %0d, expected %0d", out_entry_index, a.idx));
      end
    end
  end

  initial begin
    row_t plan[$];
    row_t r;
    int size;
    int prefix;
    int span;
    int fulls;
    int i;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows
    plan.push_back(mk_exp(0, 0, 0));            // not ready yet
    plan.push_back(mk(KIND_LOAD, 0, 0));
    plan.push_back(mk(KIND_LOAD, 1, 0));
    plan.push_back(mk(KIND_LOAD, 2, 1));
    plan.push_back(mk_exp(0, 1, 0));
    plan.push_back(mk_exp(2, 1, 2));
    plan.push_back(mk_exp(-1, 1, 1));           // negative folds to abs
    plan.push_back(mk_exp(256, 0, 0));          // rejected
    plan.push_back(mk_exp(65535, 0, 0));
    plan.push_back(mk_exp(-65535, 0, 0));
    plan.push_back(mk_exp(3, 0, 0));
    plan.push_back(mk(KIND_LOAD, 7, 0));        // discards the old table
    plan.push_back(mk(KIND_LOOKUP, 0, 0));
    plan.push_back(mk(KIND_LOAD, -7, 0));
    plan.push_back(mk(KIND_LOAD, -1, 0));
    plan.push_back(mk(KIND_LOAD, 255, 0));
    plan.push_back(mk(KIND_LOAD, 3, 1));
    plan.push_back(mk(KIND_LOOKUP, 7, 0));
    plan.push_back(mk(KIND_LOOKUP, 1, 0));
    plan.push_back(mk(KIND_LOOKUP, 255, 1));
    plan.push_back(mk(KIND_LOOKUP, -3, 0));
    plan.push_back(mk(KIND_LOOKUP, 0, 0));
    foreach (plan[k]) send(plan[k]);

    // sender pauses until the block has drained
    in_valid = 1'b0;
    wait (answer_q.size() == 0);
    repeat (20) @(negedge clk);

    fulls = 0;
    while (items < 1150) begin
      if (fulls < 2 && items > 300 * (fulls + 1)) begin
        size = MAX_ENTRIES + 4;                 // overfills, extra keys dropped
        fulls++;
      end else begin
        size = $urandom_range(1, 24);
      end
      span = $urandom_range(0, 1) ? size + 4 : 300;
      prefix = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, size);
      for (i = 0; i < size; i++) begin
        r = mk(KIND_LOAD, i < prefix ? i : rand_key(span), i == size - 1);
        if ($urandom_range(0, 40) == 0) r.last = 0;  // broken table, stays not ready
        send(r);
      end
      if (items > 200 && items < 260) hold_req = 1;  // receiver holds while we push
      repeat ($urandom_range(4, 30)) send(mk(KIND_LOOKUP, rand_key(span),
                                               $urandom_range(0, 1)));
    end
    in_valid = 1'b0;

    while (answer_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
